/* hw/rtl/mhti_pkg.sv */
// ----------------------------------------------------------------------------
// mhti_pkg
// Field widths, status and action codes for the modulo hash table.
// ----------------------------------------------------------------------------
package mhti_pkg;

	localparam int KEY_W  = 31;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 9;

	typedef logic [STAT_W-1:0] status_t;

	localparam status_t STATUS_DONE      = 2'd0;
	localparam status_t STATUS_FULL      = 2'd1;
	localparam status_t STATUS_NOT_FOUND = 2'd2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_FIND   = 1'b1;

	localparam logic [CNT_W-1:0]       CNT_RESET = 9'd256;
	localparam logic signed [VAL_W-1:0] NO_VALUE = '1;

endpackage

/* hw/rtl/mhti_ifs.sv */
// ----------------------------------------------------------------------------
// mhti_ifs
// Request and response channels of the hash table, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhti_req_if import mhti_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [KEY_W-1:0]        key;
	logic signed [VAL_W-1:0] value;

	modport source(output valid, action, key, value, input ready);
	modport sink(input valid, action, key, value, output ready);
endinterface

interface mhti_rsp_if import mhti_pkg::*; ();
	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic signed [VAL_W-1:0] found_value;

	modport source(output valid, status, found_value, input ready);
	modport sink(input valid, status, found_value, output ready);
endinterface

/* hw/rtl/modulo_hash_table_insert_find_top.sv */
// ----------------------------------------------------------------------------
// modulo_hash_table_insert_find_top
// Key-value table, bucket = key mod bucket_count, WAYS entries per bucket.
// One request at a time. The bucket index comes from a restoring divider
// that retires one key bit per cycle in ST_DIV; then the bucket fill count
// is read from its RAM in ST_FILL and ST_DECIDE. An insert finishes there.
// A find then reads the entry RAM one way at a time (states ST_FRD and
// ST_FCHK), oldest first, stopping at the first match or after the fill
// count of ways (at most WAYS). After reset, the fill RAM is cleared one
// bucket per cycle, all BUCKETS of them, before the first request is taken;
// cfg writes are taken meanwhile. Duplicate keys are kept; a find returns
// the oldest match, an insert into a full bucket is dropped (status full).
// ----------------------------------------------------------------------------
module modulo_hash_table_insert_find_top import mhti_pkg::*; #(
	parameter int BUCKETS = 256,
	parameter int WAYS    = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	mhti_req_if.sink         req,
	mhti_rsp_if.source       rsp
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int FW = $clog2(WAYS + 1);
	localparam int EW = KEY_W + VAL_W;
	localparam int ED = BUCKETS * WAYS;
	localparam int AW = (ED > 1) ? $clog2(ED) : 1;
	localparam int BIT_W = $clog2(KEY_W);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_FILL   = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_FRD    = 3'd5;
	localparam logic [2:0] ST_FCHK   = 3'd6;
	localparam logic [2:0] ST_RESULT = 3'd7;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        bc_q;
	logic [CNT_W-1:0]        div_q;
	logic [CNT_W-1:0]        div_d;
	logic [CNT_W-1:0]        rem_q;
	logic [BIT_W-1:0]        bit_q;
	logic [BW-1:0]           clr_q;
	logic                    action_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [VAL_W-1:0] value_q;
	logic [AW-1:0]           base_q;
	logic [FW-1:0]           fill_q;
	logic [FW-1:0]           way_q;
	status_t                 res_status_q;
	logic signed [VAL_W-1:0] res_value_q;
	logic                    rsp_valid_q;
	status_t                 rsp_status_q;
	logic signed [VAL_W-1:0] rsp_value_q;

	logic [CNT_W:0]   trial;
	logic             trial_ge;
	logic [BW-1:0]    bucket;
	logic [FW-1:0]    fill_rd;
	logic [FW-1:0]    fill_c;
	logic             fill_we;
	logic [BW-1:0]    fill_waddr;
	logic [FW-1:0]    fill_wdata;
	logic             ent_we;
	logic [AW-1:0]    ent_waddr;
	logic [AW-1:0]    ent_raddr;
	logic [EW-1:0]    ent_rdata;
	logic             accept;
	logic             rsp_load;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp_load = (state_q == ST_RESULT) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		if (bc_q == '0) begin
			div_d = CNT_W'(1);
		end else if (int'(bc_q) > BUCKETS) begin
			div_d = CNT_W'(BUCKETS);
		end else begin
			div_d = bc_q;
		end
	end

	assign trial    = {rem_q, key_q[bit_q]};
	assign trial_ge = (trial >= {1'b0, div_q});
	assign bucket   = BW'(rem_q);

	assign fill_c = (fill_rd > FW'(WAYS)) ? FW'(WAYS) : fill_rd;

	always_comb begin
		fill_we    = 1'b0;
		fill_waddr = bucket;
		fill_wdata = fill_c + FW'(1);
		ent_we     = 1'b0;
		if (state_q == ST_CLEAR) begin
			fill_we    = 1'b1;
			fill_waddr = clr_q;
			fill_wdata = '0;
		end else if (state_q == ST_DECIDE && action_q == ACT_INSERT &&
			fill_c != FW'(WAYS)) begin
			fill_we = 1'b1;
			ent_we  = 1'b1;
		end
	end

	assign ent_waddr = base_q + AW'(fill_c);
	assign ent_raddr = base_q + AW'(way_q);

	mhti_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (bucket),
		.rdata (fill_rd)
	);

	mhti_ram #(.WIDTH(EW), .DEPTH(ED)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata ({key_q, value_q}),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= CNT_RESET;
		end else if (cfg_we) begin
			bc_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			bit_q   <= '0;
			way_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						bit_q   <= BIT_W'(KEY_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					bit_q <= bit_q - BIT_W'(1);
					if (bit_q == '0) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					way_q <= '0;
					if (action_q == ACT_FIND && fill_c != '0) begin
						state_q <= ST_FRD;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_FRD: begin
					state_q <= ST_FCHK;
				end
				ST_FCHK: begin
					way_q <= way_q + FW'(1);
					if (ent_rdata[EW-1 -: KEY_W] == key_q || way_q + FW'(1) == fill_q) begin
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_FRD;
					end
				end
				ST_RESULT: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					action_q <= req.action;
					key_q    <= req.key;
					value_q  <= req.value;
					div_q    <= div_d;
					rem_q    <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= trial_ge ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
			end
			ST_FILL: begin
				base_q <= AW'(bucket) * AW'(WAYS);
			end
			ST_DECIDE: begin
				fill_q      <= fill_c;
				res_value_q <= NO_VALUE;
				if (action_q == ACT_INSERT) begin
					res_status_q <= (fill_c == FW'(WAYS)) ? STATUS_FULL : STATUS_DONE;
				end else begin
					res_status_q <= STATUS_NOT_FOUND;
				end
			end
			ST_FCHK: begin
				if (ent_rdata[EW-1 -: KEY_W] == key_q) begin
					res_status_q <= STATUS_DONE;
					res_value_q  <= ent_rdata[VAL_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_value_q  <= res_value_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_value = rsp_value_q;

endmodule

/* hw/rtl/mhti_ram.sv */
// ----------------------------------------------------------------------------
// mhti_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mhti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/mhti_checker.sv */
// ----------------------------------------------------------------------------
// mhti_checker
// Port-level checks on the hash table top, attached by bind.
// ----------------------------------------------------------------------------
module mhti_checker import mhti_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_ready,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input status_t                 rsp_status,
	input logic signed [VAL_W-1:0] rsp_found_value
);

	// one request in flight: ready drops right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == STATUS_DONE || rsp_status == STATUS_FULL ||
			rsp_status == STATUS_NOT_FOUND))
		else $error("undefined status code");

	a_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STATUS_DONE |-> rsp_found_value == NO_VALUE)
		else $error("failed request carries a value");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_found_value))
		else $error("stalled response changed");

endmodule

bind modulo_hash_table_insert_find_top mhti_checker u_mhti_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_value (rsp.found_value)
);
